FILE: src/swap_slot_directory_top_assert.svh
// assertion macros for the swap slot directory
`ifndef SWAP_SLOT_DIRECTORY_TOP_ASSERT_SVH
`define SWAP_SLOT_DIRECTORY_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define SSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("swap slot directory check failed");

// condition must never be seen outside reset
`define SSD_ASSERT_NEVER(label, cond) \
  `SSD_ASSERT(label, !(cond))

`endif

FILE: src/ssd_pkg.sv
// types and constants shared by the swap slot directory
package ssd_pkg;

  localparam int unsigned PageW = 20;
  localparam int unsigned SlotW = 8;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_ALLOC = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // request token that walks the cell row
  typedef struct packed {
    logic             valid;
    logic             func;
    logic [PageW-1:0] page;
    logic             done;
    status_e          status;
    logic [SlotW-1:0] slot;
  } tok_t;

endpackage

FILE: src/ssd_req_if.sv
// request channel: operation and page number
interface ssd_req_if
  import ssd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             func;
  logic [PageW-1:0] page_number;

  modport source (output valid, output func, output page_number, input ready);
  modport sink   (input valid, input func, input page_number, output ready);
endinterface

FILE: src/ssd_rsp_if.sv
// response channel: status and slot index
interface ssd_rsp_if
  import ssd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [SlotW-1:0] slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

FILE: src/ssd_cell.sv
// one directory slot: used mark, page tag and a token stage
module ssd_cell
  import ssd_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  tok_t             tok_d, tok_q;
  logic             used_d, used_q;
  logic [PageW-1:0] page_d, page_q;

  always_comb begin
    tok_d  = tok_i;
    used_d = used_q;
    page_d = page_q;
    if (tok_i.valid && !tok_i.done) begin
      if (used_q) begin
        if (page_q == tok_i.page) begin
          tok_d.done   = 1'b1;
          tok_d.status = ST_HIT;
          tok_d.slot   = SlotW'(Idx);
        end
      end else begin
        // used slots form a prefix, so nothing past the first free one can hit
        tok_d.done = 1'b1;
        if (tok_i.func) begin
          used_d       = 1'b1;
          page_d       = tok_i.page;
          tok_d.status = ST_ALLOC;
          tok_d.slot   = SlotW'(Idx);
        end else begin
          tok_d.status = ST_MISS;
          tok_d.slot   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      used_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign tok_o = tok_q;

endmodule

FILE: src/swap_slot_directory_top.sv
// swap slot directory top level: request intake, row of slot cells, response register
// a request's token walks the row of slot cells one cell per cycle into the response register;
// a request is taken only when idle, and the block stays busy until its response is taken
// reset clears every used mark and the pipeline; page tags are not cleared
module swap_slot_directory_top
  import ssd_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssd_req_if.sink   req_i,
  ssd_rsp_if.source rsp_o
);

  `include "swap_slot_directory_top_assert.svh"

  tok_t tok [SLOTS+1];
  tok_t tok_end;

  logic             busy_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [SlotW-1:0] out_slot_q;

  logic req_fire;
  logic rsp_fire;

  assign req_i.ready = !busy_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = req_fire;
    tok[0].func   = req_i.func;
    tok[0].page   = req_i.page_number;
    tok[0].done   = 1'b0;
    tok[0].status = ST_HIT;
    tok[0].slot   = '0;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ssd_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  // a token that passed every cell unresolved found the table full of other pages
  always_comb begin
    tok_end = tok[SLOTS];
    if (!tok_end.done) begin
      tok_end.status = tok_end.func ? ST_FULL : ST_MISS;
      tok_end.slot   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rsp_fire) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b0;
      end
      if (req_fire) begin
        busy_q <= 1'b1;
      end
      if (tok_end.valid) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end.valid) begin
      out_status_q <= tok_end.status;
      out_slot_q   <= tok_end.slot;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot_index = out_slot_q;

  `SSD_ASSERT(a_rsp_only_when_busy, rsp_o.valid |-> busy_q)
  `SSD_ASSERT_NEVER(a_token_over_pending_rsp, tok_end.valid && out_valid_q)
  `SSD_ASSERT(a_accept_blocks_next, req_fire |=> !req_i.ready)
  `SSD_ASSERT(a_miss_slot_zero,
    (rsp_o.valid && (rsp_o.status == ST_MISS || rsp_o.status == ST_FULL))
      |-> (rsp_o.slot_index == '0))

endmodule

FILE: tb/tb_swap_slot_directory_top.sv
`timescale 1ns / 1ps
// testbench for the swap slot directory: lookup and store requests checked against a slot table
module tb_swap_slot_directory_top;
  import ssd_pkg::*;

  localparam int unsigned DirSlots       = 256;
  localparam int unsigned RandomRequests = 1935;
  localparam int unsigned PoolSize       = 320;
  localparam int unsigned LongHold       = 1500;
  localparam int unsigned IdleLimit      = 20000;
  localparam int unsigned ReportMax      = 10;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
  } dir_answer_t;

  // mirror of the slot table plus the answers still owed by the block
  class slot_dir_board;
    logic [PageW-1:0] slot_page [DirSlots];
    bit               slot_used [DirSlots];
    dir_answer_t      answers_due [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      status_seen [4];

    function void note_request(logic func, logic [PageW-1:0] page);
      int          hit_slot;
      int          free_slot;
      int          i;
      dir_answer_t ans;
      hit_slot  = -1;
      free_slot = -1;
      // lowest matching used slot wins, lowest unused slot is the free one
      for (i = 0; i < DirSlots; i++) begin
        if (slot_used[i]) begin
          if (hit_slot < 0 && slot_page[i] == page) hit_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit_slot >= 0) begin
        ans.status = ST_HIT;
        ans.slot   = SlotW'(hit_slot);
      end else if (!func) begin
        ans.status = ST_MISS;
        ans.slot   = '0;
      end else if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_page[free_slot] = page;
        ans.status = ST_ALLOC;
        ans.slot   = SlotW'(free_slot);
      end else begin
        ans.status = ST_FULL;
        ans.slot   = '0;
      end
      status_seen[ans.status]++;
      answers_due.push_back(ans);
    endfunction

    function void check_response(logic [1:0] status, logic [SlotW-1:0] slot);
      dir_answer_t ans;
      checked++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected word: status %0d slot %0d", status, slot);
        return;
      end
      ans = answers_due.pop_front();
      if (status !== ans.status || slot !== ans.slot) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("mismatch: expected status %s slot %0d, got status %0d slot %0d",
                   ans.status.name(), ans.slot, status, slot);
      end
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ssd_req_if req_if ();
  ssd_rsp_if rsp_if ();

  swap_slot_directory_top #(
    .SLOTS(DirSlots)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  slot_dir_board    board = new();
  logic [PageW-1:0] page_pool [PoolSize];
  int unsigned      idle_cycles = 0;
  bit               hold_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // offer one word and wait until it is taken
  task automatic push_request(logic func, logic [PageW-1:0] page);
    int unsigned gap;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) gap = $urandom_range(0, 2);
    else if (pick < 95) gap = $urandom_range(3, 40);
    else gap = $urandom_range(41, 300);
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.func        <= func;
    req_if.page_number <= page;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(func, page);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // mostly pages from a pool a bit larger than the table, so hits, fills and full stores occur
  function automatic logic [PageW-1:0] pick_page();
    if ($urandom_range(0, 99) < 70) return page_pool[$urandom_range(0, PoolSize - 1)];
    return PageW'($urandom);
  endfunction

  initial begin : rsp_ready_driver
    int unsigned stall_left;
    int unsigned quiet_left;
    int unsigned pick;
    stall_left    = 0;
    quiet_left    = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LongHold;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (quiet_left > 0) begin
        rsp_if.ready <= 1'b1;
        quiet_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          quiet_left   = $urandom_range(200, 2000);
          rsp_if.ready <= 1'b1;
        end else if (pick < 8) begin
          stall_left   = $urandom_range(100, 600);
          rsp_if.ready <= 1'b0;
        end else if (pick < 30) begin
          stall_left   = $urandom_range(0, 3);
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      board.check_response(rsp_if.status, rsp_if.slot_index);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no word moved for %0d cycles, %0d answers owed",
               idle_cycles, board.pending());
      $display("tb_swap_slot_directory_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned n;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = 1'b0;
    req_if.page_number = '0;
    for (n = 0; n < PoolSize; n++) page_pool[n] = PageW'($urandom);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extreme pages, hits on both paths, alternating bit patterns
    push_request(1'b0, 20'h00000);
    push_request(1'b0, 20'hFFFFF);
    push_request(1'b1, 20'h00000);
    push_request(1'b1, 20'hFFFFF);
    push_request(1'b0, 20'h00000);
    push_request(1'b0, 20'hFFFFF);
    push_request(1'b1, 20'h00000);
    push_request(1'b0, 20'h55555);
    push_request(1'b1, 20'hAAAAA);
    push_request(1'b1, 20'h55555);
    push_request(1'b0, 20'hAAAAA);
    push_request(1'b1, 20'hFFFFF);
    push_request(1'b0, 20'h00001);
    push_request(1'b1, 20'h80000);
    push_request(1'b0, 20'h80000);
    wait_drained();

    for (n = 0; n < RandomRequests; n++) begin
      if (n == 600) hold_request = 1'b1;
      if (n == 1200) wait_drained();
      push_request($urandom_range(0, 99) < 60, pick_page());
    end

    wait_drained();
    repeat (DirSlots + 20) @(posedge clk_i);

    $display("%0d answers checked: %0d hits, %0d allocations, %0d lookup misses, %0d full stores",
             board.checked, board.status_seen[ST_HIT], board.status_seen[ST_ALLOC],
             board.status_seen[ST_MISS], board.status_seen[ST_FULL]);
    if (board.pending() != 0)
      $display("%0d answers never arrived", board.pending());
    if (board.mismatches != 0)
      $display("%0d mismatches in total", board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_swap_slot_directory_top: PASS");
    end else begin
      $display("tb_swap_slot_directory_top: FAIL");
    end
    $finish;
  end

endmodule
